// ===== rtl/sha1md_pkg.sv =====
// Shared types and constants for the SHA-1 message digest block.
// Used by the top level and the round function. No dependencies.
package sha1md_pkg;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // Five 32-bit working or chaining words, a is the most significant.
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } t_vars;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_PRIME,
        ST_ROUND,
        ST_FINISH
    } t_state;

    localparam t_vars INIT_CHAIN = '{
        a: 32'h6745_2301,
        b: 32'hEFCD_AB89,
        c: 32'h98BA_DCFE,
        d: 32'h1032_5476,
        e: 32'hC3D2_E1F0
    };

    localparam logic [31:0] K_CH     = 32'h5A82_7999;
    localparam logic [31:0] K_PAR_LO = 32'h6ED9_EBA1;
    localparam logic [31:0] K_MAJ    = 32'h8F1B_BCDC;
    localparam logic [31:0] K_PAR_HI = 32'hCA62_C1D6;

    localparam logic [31:0] PAD_ONE      = 32'h8000_0000;
    localparam logic [6:0]  CH_END       = 7'd20;
    localparam logic [6:0]  PAR_LO_END   = 7'd40;
    localparam logic [6:0]  MAJ_END      = 7'd60;
    localparam logic [6:0]  SCHED_START  = 7'd16;
    localparam logic [6:0]  LAST_ROUND   = 7'd79;
    localparam logic [3:0]  LAST_FILL    = 4'd15;
    localparam logic [3:0]  LEN_HI_FILL  = 4'd14;
    localparam logic [2:0]  FULL_COUNT   = 3'd4;
    localparam logic [2:0]  LAST_INDEX   = 3'd4;

endpackage

// ===== rtl/sha1_message_digest.sv =====
// SHA-1 message digest top level: input sequencer, padding, round loop, digest output.
// Depends on sha1md_pkg, sha1md_ram and sha1md_round.
//
//   channel | direction | handshake                 | item
//   --------+-----------+---------------------------+------------------------------
//   input   | in        | i_in_valid / o_in_stall   | t_in_item: word, count, last
//   output  | out       | o_out_valid / i_out_stall | t_out_item: digest word, index
//
// Every sixteenth message word starts a compression: read priming, then the round loop
// at one round a cycle, then the chaining update. After the last word the padding words
// go in one a cycle (up to 15 in the block that holds the last word, and 16 more when
// the length spills into a second block), then one or two blocks are compressed. Reset
// clears all control state and reloads the initial chaining words; the block buffer
// needs no clearing. Digest items drain from an output register while the next message
// enters; only a digest finishing while the previous one is still stalled waits for it.
module sha1_message_digest import sha1md_pkg::*; #(
    parameter int LENGTH_BITS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    // Control state.
    t_state                 r_state, n_state;
    logic [3:0]             r_fill, n_fill;
    logic [6:0]             r_round, n_round;
    logic [LENGTH_BITS-1:0] r_bits, n_bits;
    logic                   r_padding, n_padding;
    logic                   r_need_one, n_need_one;
    logic                   r_hi_done, n_hi_done;
    logic                   r_out_busy, n_out_busy;
    logic [2:0]             r_out_idx, n_out_idx;
    t_vars                  r_chain, n_chain;

    // Payload registers: working variables, recent schedule words, digest buffer.
    t_vars       r_vars;
    t_vars       r_dig;
    logic [31:0] r_hist [8];

    logic        in_take;
    logic        out_take;
    logic        push;
    logic        digest_load;
    logic [2:0]  cnt;
    logic [31:0] last_word_val;
    logic [31:0] push_word;
    logic [63:0] len64;
    logic [31:0] w_round;
    logic [31:0] w_sched;
    logic [6:0]  rd_base;
    logic        ram_we;
    logic [3:0]  ram_waddr;
    logic [31:0] ram_wdata;
    logic [31:0] ram_a;
    logic [31:0] ram_b;
    t_vars       round_out;
    t_vars       chain_sum;

    // The block buffer, which also holds the rolling message schedule during rounds.
    sha1md_ram #(
        .WIDTH (32),
        .DEPTH (16)
    ) u_buffer (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (4'(rd_base + 7'd2)),
        .i_raddr_b (rd_base[3:0]),
        .o_rdata_a (ram_a),
        .o_rdata_b (ram_b)
    );

    sha1md_round u_round (
        .i_vars  (r_vars),
        .i_w     (w_round),
        .i_round (r_round),
        .o_vars  (round_out)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    if (r_fill == LAST_FILL) begin
                        n_state = ST_PRIME;
                    end else if (i_in_item.last) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (r_fill == LAST_FILL) begin
                    n_state = ST_PRIME;
                end
            end
            ST_PRIME: begin
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                if (r_round == LAST_ROUND) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (r_hi_done) begin
                    if (!r_out_busy) begin
                        n_state = ST_IDLE;
                    end
                end else if (r_padding) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State decodes. Input is only taken when the sequencer has nothing else to do.
    always_comb begin
        o_in_stall  = (r_state != ST_IDLE) || !i_rst_n;
        push        = (r_state == ST_PAD);
        digest_load = (r_state == ST_FINISH) && r_hi_done && !r_out_busy;
        // In the round loop the reads are issued one round ahead; while priming,
        // for round zero.
        rd_base     = (r_state == ST_ROUND) ? r_round + 7'd1 : r_round;
        ram_we      = 1'b0;
        case (r_state)
            ST_IDLE:  ram_we = in_take;
            ST_PAD:   ram_we = 1'b1;
            ST_ROUND: ram_we = (r_round >= SCHED_START);
            default:  ram_we = 1'b0;
        endcase
    end

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_take = r_out_busy && !i_out_stall;

    // Last word: keep the valid bytes and place the single one bit right after them.
    assign cnt           = (i_in_item.byte_count > FULL_COUNT) ? FULL_COUNT
                                                               : i_in_item.byte_count;
    assign last_word_val = (cnt == FULL_COUNT) ? i_in_item.data_word
                         : (i_in_item.data_word & ~(32'hFFFF_FFFF >> {cnt, 3'b000}))
                           | (PAD_ONE >> {cnt, 3'b000});

    assign len64 = 64'(r_bits);

    always_comb begin
        if (r_state == ST_IDLE) begin
            push_word = i_in_item.last ? last_word_val : i_in_item.data_word;
        end else if (r_need_one) begin
            push_word = PAD_ONE;
        end else if (r_fill == LEN_HI_FILL) begin
            push_word = len64[63:32];
        end else if (r_fill == LAST_FILL && r_hi_done) begin
            push_word = len64[31:0];
        end else begin
            push_word = '0;
        end
    end

    // Schedule: w[t-3] and w[t-8] from the history line, w[t-14] and w[t-16] from RAM.
    assign w_sched = {r_hist[2][30:0] ^ r_hist[7][30:0] ^ ram_a[30:0] ^ ram_b[30:0],
                      r_hist[2][31] ^ r_hist[7][31] ^ ram_a[31] ^ ram_b[31]};
    assign w_round = (r_round < SCHED_START) ? ram_b : w_sched;

    assign ram_waddr = (r_state == ST_ROUND) ? r_round[3:0] : r_fill;
    assign ram_wdata = (r_state == ST_ROUND) ? w_sched : push_word;

    assign chain_sum = '{
        a: r_chain.a + r_vars.a,
        b: r_chain.b + r_vars.b,
        c: r_chain.c + r_vars.c,
        d: r_chain.d + r_vars.d,
        e: r_chain.e + r_vars.e
    };

    // Next values of the counters, length and flags.
    always_comb begin
        n_fill     = r_fill;
        n_round    = r_round;
        n_bits     = r_bits;
        n_padding  = r_padding;
        n_need_one = r_need_one;
        n_hi_done  = r_hi_done;
        n_chain    = r_chain;
        n_out_busy = r_out_busy;
        n_out_idx  = r_out_idx;

        if (in_take || push) begin
            n_fill = r_fill + 4'd1;
        end
        if (in_take) begin
            if (i_in_item.last) begin
                n_bits     = r_bits + LENGTH_BITS'({cnt, 3'b000});
                n_padding  = 1'b1;
                n_need_one = (cnt == FULL_COUNT);
            end else begin
                n_bits = r_bits + LENGTH_BITS'(32);
            end
        end
        if (push) begin
            n_need_one = 1'b0;
            if (!r_need_one && r_fill == LEN_HI_FILL) begin
                n_hi_done = 1'b1;
            end
        end
        if (r_state == ST_ROUND) begin
            n_round = (r_round == LAST_ROUND) ? '0 : r_round + 7'd1;
        end
        if (r_state == ST_FINISH && !r_hi_done) begin
            n_chain = chain_sum;
        end
        if (out_take) begin
            n_out_idx = r_out_idx + 3'd1;
            if (r_out_idx == LAST_INDEX) begin
                n_out_busy = 1'b0;
            end
        end
        // The final block's sum goes straight to the output buffer and the chaining
        // words return to their initial values for the next message.
        if (digest_load) begin
            n_chain    = INIT_CHAIN;
            n_bits     = '0;
            n_padding  = 1'b0;
            n_hi_done  = 1'b0;
            n_out_busy = 1'b1;
            n_out_idx  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_fill     <= '0;
            r_round    <= '0;
            r_bits     <= '0;
            r_padding  <= 1'b0;
            r_need_one <= 1'b0;
            r_hi_done  <= 1'b0;
            r_out_busy <= 1'b0;
            r_out_idx  <= '0;
            r_chain    <= INIT_CHAIN;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_round    <= n_round;
            r_bits     <= n_bits;
            r_padding  <= n_padding;
            r_need_one <= n_need_one;
            r_hi_done  <= n_hi_done;
            r_out_busy <= n_out_busy;
            r_out_idx  <= n_out_idx;
            r_chain    <= n_chain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_PRIME) begin
            r_vars <= r_chain;
        end else if (r_state == ST_ROUND) begin
            r_vars <= round_out;
        end
        if (r_state == ST_ROUND) begin
            r_hist[0] <= w_round;
            for (int i = 1; i < 8; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
        end
        if (digest_load) begin
            r_dig <= chain_sum;
        end
    end

    // Digest output register.
    assign o_out_valid = r_out_busy;

    always_comb begin
        o_out_item.word_index = r_out_idx;
        o_out_item.last_word  = (r_out_idx == LAST_INDEX);
        case (r_out_idx)
            3'd0:    o_out_item.digest_word = r_dig.a;
            3'd1:    o_out_item.digest_word = r_dig.b;
            3'd2:    o_out_item.digest_word = r_dig.c;
            3'd3:    o_out_item.digest_word = r_dig.d;
            default: o_out_item.digest_word = r_dig.e;
        endcase
    end

    // The round loop always hands over to the chaining update after its final round.
    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_round == LAST_ROUND) |=> (r_state == ST_FINISH))
        else $error("round loop did not end in the chaining update");

    // A compression only starts on a freshly completed block.
    a_prime_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PRIME) |-> (r_fill == '0 && r_round == '0))
        else $error("compression started on a partial block");

    // The length words are only written while a message is being padded.
    a_hi_in_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hi_done |-> r_padding)
        else $error("length written outside padding");

    // Once started, a digest keeps presenting items until its fifth one is taken.
    a_digest_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_busy && r_out_idx != LAST_INDEX) |=> r_out_busy)
        else $error("digest output dropped before its last word");

endmodule

// ===== rtl/sha1md_ram.sv =====
// Generic synchronous RAM: one write port, two read ports, registered reads.
// Stand-alone, no package dependency.
module sha1md_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== rtl/sha1md_round.sv =====
// One SHA-1 compression round: round function, constant and the a..e shuffle.
// Depends on sha1md_pkg for t_vars and the round constants.
module sha1md_round import sha1md_pkg::*; (
    input  t_vars       i_vars,
    input  logic [31:0] i_w,
    input  logic [6:0]  i_round,
    output t_vars       o_vars
);

    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] t;

    always_comb begin
        if (i_round < CH_END) begin
            f = (i_vars.b & i_vars.c) | (~i_vars.b & i_vars.d);
            k = K_CH;
        end else if (i_round < PAR_LO_END) begin
            f = i_vars.b ^ i_vars.c ^ i_vars.d;
            k = K_PAR_LO;
        end else if (i_round < MAJ_END) begin
            f = (i_vars.b & i_vars.c) | (i_vars.b & i_vars.d) | (i_vars.c & i_vars.d);
            k = K_MAJ;
        end else begin
            f = i_vars.b ^ i_vars.c ^ i_vars.d;
            k = K_PAR_HI;
        end
    end

    assign t = {i_vars.a[26:0], i_vars.a[31:27]} + f + i_vars.e + k + i_w;

    assign o_vars = '{
        a: t,
        b: i_vars.a,
        c: {i_vars.b[1:0], i_vars.b[31:2]},
        d: i_vars.c,
        e: i_vars.d
    };

endmodule
